/* hw/rtl/adc_key_ladder_debounce_macros.svh */
// assertion macros shared by the keypad debounce checker
// clocked on clk, disabled while arst_n is low
`ifndef ADC_KEY_LADDER_DEBOUNCE_MACROS_SVH
`define ADC_KEY_LADDER_DEBOUNCE_MACROS_SVH

// same-cycle implication
`define AKL_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define AKL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/akl_pkg.sv */
// shared types, constants and helpers for the keypad ladder debounce block
// no dependencies
package akl_pkg;

	// configuration port shape
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	// compare width: covers a 16-bit sample plus a 12-bit window and the top key level
	localparam int CMP_W = 18;

	// result word width
	localparam int OUT_W = 8;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_JITTER_WINDOW  = 3'd0,
		REG_LEVEL_BASE     = 3'd1,
		REG_LEVEL_STEP     = 3'd2,
		REG_CONFIRM_COUNT  = 3'd3,
		REG_PRESS_DELAY    = 3'd4,
		REG_RELEASE_DELAY  = 3'd5
	} cfg_reg_t;

	// register reset values
	localparam logic [11:0] RST_JITTER_WINDOW = 12'h040;
	localparam logic [11:0] RST_LEVEL_BASE    = 12'h100;
	localparam logic [11:0] RST_LEVEL_STEP    = 12'h100;
	localparam logic [3:0]  RST_CONFIRM_COUNT = 4'd2;
	localparam logic [7:0]  RST_PRESS_DELAY   = 8'd5;
	localparam logic [7:0]  RST_RELEASE_DELAY = 8'd2;

	typedef struct packed {
		logic [11:0] jitter_window;
		logic [11:0] level_base;
		logic [11:0] level_step;
		logic [3:0]  confirm_count;
		logic [7:0]  press_delay_ms;
		logic [7:0]  release_delay_ms;
	} cfg_t;

	// window match result
	typedef struct packed {
		logic       have;
		logic [2:0] key;
	} match_t;

	// debounce phases, one-hot
	typedef enum logic [3:0] {
		PH_IDLE      = 4'b0001,
		PH_PRESSING  = 4'b0010,
		PH_PRESSED   = 4'b0100,
		PH_RELEASING = 4'b1000
	} phase_t;

	// phase codes as seen on the result word
	localparam logic [1:0] PH_CODE_IDLE      = 2'd0;
	localparam logic [1:0] PH_CODE_PRESSING  = 2'd1;
	localparam logic [1:0] PH_CODE_PRESSED   = 2'd2;
	localparam logic [1:0] PH_CODE_RELEASING = 2'd3;

	// held key, no-key flag and phase code
	typedef struct packed {
		logic [2:0] held_key;
		logic       no_key;
		logic [1:0] phase;
	} status_t;

	function automatic logic [1:0] phase_code(input phase_t p);
		logic [1:0] c;
		unique case (p)
			PH_IDLE:      c = PH_CODE_IDLE;
			PH_PRESSING:  c = PH_CODE_PRESSING;
			PH_PRESSED:   c = PH_CODE_PRESSED;
			PH_RELEASING: c = PH_CODE_RELEASING;
			default:      c = PH_CODE_IDLE;
		endcase
		return c;
	endfunction

endpackage

/* hw/rtl/akl_cfg_regs.sv */
// configuration register file for the keypad ladder debounce block
// depends on akl_pkg
module akl_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [akl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [akl_pkg::CFG_DATA_W-1:0] cfg_data,
	output akl_pkg::cfg_t                  cfg
);
	import akl_pkg::*;

	cfg_t cfg_q;

	// writes are taken every cycle
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// register write, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.jitter_window    <= RST_JITTER_WINDOW;
			cfg_q.level_base       <= RST_LEVEL_BASE;
			cfg_q.level_step       <= RST_LEVEL_STEP;
			cfg_q.confirm_count    <= RST_CONFIRM_COUNT;
			cfg_q.press_delay_ms   <= RST_PRESS_DELAY;
			cfg_q.release_delay_ms <= RST_RELEASE_DELAY;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_JITTER_WINDOW: cfg_q.jitter_window    <= cfg_data;
				REG_LEVEL_BASE:    cfg_q.level_base       <= cfg_data;
				REG_LEVEL_STEP:    cfg_q.level_step       <= cfg_data;
				REG_CONFIRM_COUNT: cfg_q.confirm_count    <= cfg_data[3:0];
				REG_PRESS_DELAY:   cfg_q.press_delay_ms   <= cfg_data[7:0];
				REG_RELEASE_DELAY: cfg_q.release_delay_ms <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

endmodule

/* hw/rtl/akl_key_match.sv */
// ladder level window match: one compare pair per key, lowest key wins
// depends on akl_pkg
module akl_key_match #(
	parameter int NUM_KEYS    = 6,
	parameter int SAMPLE_BITS = 12
) (
	input  logic [SAMPLE_BITS-1:0] sample,
	input  akl_pkg::cfg_t          cfg,
	output akl_pkg::match_t        match
);
	import akl_pkg::*;

	localparam int KEY_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

	logic [CMP_W-1:0]    sample_ext;
	logic [CMP_W-1:0]    jitter_ext;
	logic [CMP_W-1:0]    sample_plus_j;
	logic [CMP_W-1:0]    lvl [NUM_KEYS];
	logic [NUM_KEYS-1:0] hit;
	logic [KEY_W-1:0]    idx;

	assign sample_ext    = CMP_W'(sample);
	assign jitter_ext    = CMP_W'(cfg.jitter_window);
	assign sample_plus_j = sample_ext + jitter_ext;

	// level - j < s < level + j, lower bound rewritten as s + j > level
	always_comb begin
		for (int k = 0; k < NUM_KEYS; k++) begin
			lvl[k] = CMP_W'(cfg.level_base) + CMP_W'(cfg.level_step) * CMP_W'(k);
			hit[k] = (sample_plus_j > lvl[k]) && (sample_ext < lvl[k] + jitter_ext);
		end
	end

	// priority pick of the lowest hit
	always_comb begin
		idx = '0;
		for (int k = NUM_KEYS - 1; k >= 0; k--) begin
			if (hit[k]) begin
				idx = KEY_W'(k);
			end
		end
	end

	assign match.have = |hit;
	assign match.key  = 3'(idx);

endmodule

/* hw/rtl/akl_debounce.sv */
// four-phase debounce machine with qualify counter and millisecond settle timer
// depends on akl_pkg
module akl_debounce (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  logic             tick,
	input  akl_pkg::match_t  match,
	input  akl_pkg::cfg_t    cfg,
	output akl_pkg::status_t status
);
	import akl_pkg::*;

	phase_t     phase_q, phase_d;
	logic [4:0] qual_q, qual_d, qual_inc;
	logic [8:0] delay_q, delay_d;
	logic [2:0] held_q, held_d;
	logic       nokey_q, nokey_d;

	assign qual_inc = qual_q + 5'd1;

	// next state for one word
	always_comb begin
		phase_d = phase_q;
		qual_d  = qual_q;
		delay_d = delay_q;
		held_d  = held_q;
		nokey_d = nokey_q;
		if (tick) begin
			// tick only runs the settle timer down
			if (delay_q != '0) begin
				delay_d = delay_q - 9'd1;
			end
		end else begin
			unique case (phase_q)
				PH_IDLE: begin
					if (match.have) begin
						qual_d = qual_inc;
						if (qual_inc > {1'b0, cfg.confirm_count}) begin
							qual_d  = '0;
							delay_d = {1'b0, cfg.press_delay_ms} + 9'd1;
							phase_d = PH_PRESSING;
						end
					end else begin
						nokey_d = 1'b1;
					end
				end
				PH_PRESSED: begin
					if (match.have) begin
						held_d  = match.key;
						nokey_d = 1'b0;
					end else begin
						qual_d = qual_inc;
						if (qual_inc > {1'b0, cfg.confirm_count}) begin
							qual_d  = '0;
							delay_d = {1'b0, cfg.release_delay_ms} + 9'd1;
							phase_d = PH_RELEASING;
						end
					end
				end
				PH_PRESSING, PH_RELEASING: begin
					// sample ignored until the settle delay has run out
					if (delay_q == '0) begin
						phase_d = match.have ? PH_PRESSED : PH_IDLE;
					end
				end
				default: phase_d = PH_IDLE;
			endcase
		end
	end

	// state update, one word per fire
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			qual_q  <= '0;
			delay_q <= '0;
			held_q  <= '0;
			nokey_q <= 1'b1;
		end else if (fire) begin
			phase_q <= phase_d;
			qual_q  <= qual_d;
			delay_q <= delay_d;
			held_q  <= held_d;
			nokey_q <= nokey_d;
		end
	end

	// state only moves when a result is loaded, so it doubles as the result register
	assign status.held_key = held_q;
	assign status.no_key   = nokey_q;
	assign status.phase    = phase_code(phase_q);

endmodule

/* hw/rtl/adc_key_ladder_debounce.sv */
// top level of the resistor-ladder keypad decoder with debounce
// depends on akl_pkg, akl_cfg_regs, akl_key_match, akl_debounce
//
// Input words arrive on s_axis: tuser is the kind (0 ADC sample, 1 one-millisecond
// tick) and tdata carries the sample in its low SAMPLE_BITS bits. Every input word
// produces exactly one result word on m_axis, carrying the held key, the no-key
// flag and the debounce phase after that word was applied.
// Registers are written on the cfg channel (index, data); cfg_ready is always high.
// Write them only while no word is in flight.
// A word accepted into the input register is presented on m_axis from the result register.
// Throughput: one word per cycle while m_axis is not stalled, set by the combinational window
// match and phase update between the input register and the state registers.
// A stalled m_axis holds its word; one further word waits in the input register,
// after which s_axis_tready drops until the receiver takes the result.
// Reset: arst_n clears both pipeline valids, puts the machine in idle with the
// no-key flag set and loads the register defaults.
module adc_key_ladder_debounce #(
	parameter  int NUM_KEYS    = 6,
	parameter  int SAMPLE_BITS = 12,
	localparam int IN_W        = ((SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// input words
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [IN_W-1:0]                s_axis_tdata,  // sample
	input  logic                           s_axis_tuser,  // cmd
	// result words
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [akl_pkg::OUT_W-1:0]      m_axis_tdata,  // key_value[2:0], no_key, phase[1:0]
	// register writes
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [akl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [akl_pkg::CFG_DATA_W-1:0] cfg_data
);
	import akl_pkg::*;

	cfg_t                   cfg;
	match_t                 match;
	status_t                status;
	logic                   valid_s1;
	logic                   cmd_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic                   out_valid_q;
	logic                   out_free;
	logic                   fire;

	// handshake between the input register and the result side
	assign out_free      = !out_valid_q || m_axis_tready;
	assign fire          = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			cmd_s1    <= s_axis_tuser;
			sample_s1 <= s_axis_tdata[SAMPLE_BITS-1:0];
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	akl_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	akl_key_match #(
		.NUM_KEYS    (NUM_KEYS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_key_match (
		.sample (sample_s1),
		.cfg    (cfg),
		.match  (match)
	);

	akl_debounce u_debounce (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.tick   (cmd_s1),
		.match  (match),
		.cfg    (cfg),
		.status (status)
	);

	// result word
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, status.phase, status.no_key, status.held_key};

endmodule

/* hw/rtl/adc_key_ladder_debounce_checker.sv */
// port-level checker for the keypad ladder debounce block, bound to the top level
// depends on akl_pkg and adc_key_ladder_debounce_macros.svh
`include "adc_key_ladder_debounce_macros.svh"

module adc_key_ladder_debounce_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_axis_tvalid,
	input logic                      s_axis_tready,
	input logic                      m_axis_tvalid,
	input logic                      m_axis_tready,
	input logic [akl_pkg::OUT_W-1:0] m_axis_tdata  // key_value[2:0], no_key, phase[1:0]
);
	import akl_pkg::*;

	logic [1:0] last_phase_q;
	logic [2:0] last_key_q;
	logic [1:0] cur_phase;
	logic [2:0] cur_key;
	logic       s_accept;
	logic       m_accept;
	logic       step_ok;
	logic       key_changed;

	assign s_accept    = s_axis_tvalid && s_axis_tready;
	assign m_accept    = m_axis_tvalid && m_axis_tready;
	assign cur_phase   = m_axis_tdata[5:4];
	assign cur_key     = m_axis_tdata[2:0];
	assign key_changed = cur_key != last_key_q;

	// legal moves of the debounce phase from one result word to the next
	always_comb begin
		unique case (last_phase_q)
			PH_CODE_IDLE:     step_ok = cur_phase == PH_CODE_IDLE || cur_phase == PH_CODE_PRESSING;
			PH_CODE_PRESSED:  step_ok = cur_phase == PH_CODE_PRESSED
				|| cur_phase == PH_CODE_RELEASING;
			PH_CODE_PRESSING: step_ok = cur_phase != PH_CODE_RELEASING;
			PH_CODE_RELEASING: step_ok = cur_phase != PH_CODE_PRESSING;
			default:          step_ok = 1'b0;
		endcase
	end

	// last delivered word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_phase_q <= PH_CODE_IDLE;
			last_key_q   <= '0;
		end else if (m_accept) begin
			last_phase_q <= cur_phase;
			last_key_q   <= cur_key;
		end
	end

	`AKL_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result word changed while stalled")
	`AKL_ASSERT(a_latency, s_accept, ##2 m_axis_tvalid, "no result word two cycles after an accepted word")
	`AKL_ASSERT(a_phase_step, m_axis_tvalid, step_ok, "illegal debounce phase move")
	`AKL_ASSERT(a_key_pressed, m_axis_tvalid && key_changed, cur_phase == PH_CODE_PRESSED, "held key changed outside pressed")

endmodule

bind adc_key_ladder_debounce adc_key_ladder_debounce_checker u_checker (.*);
